// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL in this folder.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked in the same cycle outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- src/tehf_pkg.sv -----
// Package for the tunnel exit health block: state types, event and register codes.
// No dependencies.
`timescale 1ns / 1ps

package tehf_pkg;

	typedef enum logic [1:0] {
		ST_DISABLED = 2'd0,
		ST_PENDING  = 2'd1,
		ST_ACTIVE   = 2'd2,
		ST_FALLBACK = 2'd3
	} policy_state_t;

	localparam int RUN_W = 4;
	localparam logic [RUN_W-1:0] THRESHOLD_RST = RUN_W'(3);

	// event kinds; the fourth code is a no-op
	localparam logic [1:0] MODE_RESTART = 2'd0;
	localparam logic [1:0] MODE_TUNNEL  = 2'd1;
	localparam logic [1:0] MODE_PROBE   = 2'd2;

	// configuration register indexes
	localparam logic REG_EXIT_ENABLED    = 1'b0;
	localparam logic REG_PROBE_THRESHOLD = 1'b1;

	typedef struct packed {
		policy_state_t    policy;
		logic [RUN_W-1:0] success_run;
		logic [RUN_W-1:0] failure_run;
		logic             link_up;
		logic             armed;   // enable setting latched at last restart
	} health_state_t;

	localparam health_state_t HEALTH_RST = '{
		policy:      ST_DISABLED,
		success_run: '0,
		failure_run: '0,
		link_up:     1'b0,
		armed:       1'b0
	};

endpackage

// ----- src/tunnel_exit_health_fsm_unit.sv -----
// Channel  | handshake              | payload
// ---------+------------------------+-------------------------------
// input    | in_valid / in_ready    | mode[1:0], event_flag
// output   | out_valid / out_ready  | exit_state[1:0], routes_public
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data[3:0]
//
// One word per clock sustained while out_ready stays high. An accepted word passes
// through the input register, then the result register, to the output. The state
// update for a word happens as it leaves the input register, so back-to-back words
// see each other's effects.
// Reset clears the policy state, run counters, link flag and both valid bits.
// A stalled output holds the input register; in_ready drops only then.
// Top level of the tunnel exit health block; depends on tehf_pkg, tehf_step, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tunnel_exit_health_fsm_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic                        event_flag,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  exit_state,
	output logic                        routes_public,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [tehf_pkg::RUN_W-1:0]  cfg_data
);
	import tehf_pkg::*;

	logic             exit_enabled_q;
	logic [RUN_W-1:0] probe_threshold_q;
	health_state_t    state_q;
	health_state_t    state_nxt;
	logic             routes_nxt;

	logic             valid_s1;
	logic [1:0]       mode_s1;
	logic             flag_s1;
	logic             adv;

	logic             out_valid_q;
	logic [1:0]       exit_state_q;
	logic             routes_public_q;

	logic             succ_zero;
	logic             fail_zero;
	logic             is_disabled;
	logic             out_active;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exit_enabled_q    <= 1'b0;
			probe_threshold_q <= THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXIT_ENABLED:    exit_enabled_q    <= cfg_data[0];
				REG_PROBE_THRESHOLD: probe_threshold_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			flag_s1 <= event_flag;
		end
	end

	tehf_step u_step (
		.cur             (state_q),
		.mode            (mode_s1),
		.event_flag      (flag_s1),
		.exit_enabled    (exit_enabled_q),
		.probe_threshold (probe_threshold_q),
		.nxt             (state_nxt),
		.routes_public   (routes_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HEALTH_RST;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			exit_state_q    <= 2'(state_nxt.policy);
			routes_public_q <= routes_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign exit_state    = exit_state_q;
	assign routes_public = routes_public_q;

	assign succ_zero   = (state_q.success_run == '0);
	assign fail_zero   = (state_q.failure_run == '0);
	assign is_disabled = (state_q.policy == ST_DISABLED);
	assign out_active  = (exit_state_q == 2'(ST_ACTIVE));

	// a success run and a failure run never coexist
	`ASSERT_ALWAYS(a_runs_exclusive, succ_zero || fail_zero, "both run counters nonzero")
	`ASSERT_IMPLIES(a_unarmed_disabled, !state_q.armed, is_disabled, "unarmed but not disabled")
	`ASSERT_IMPLIES(a_down_no_runs, !state_q.link_up, succ_zero && fail_zero, "run with link down")
	`ASSERT_IMPLIES(a_routes_match, out_valid_q, routes_public_q == out_active, "routes_public off")

endmodule

// ----- src/tehf_step.sv -----
// Next-state logic for one event of the tunnel exit health machine.
// Depends on tehf_pkg.
`timescale 1ns / 1ps

module tehf_step (
	input  tehf_pkg::health_state_t       cur,
	input  logic [1:0]                    mode,
	input  logic                          event_flag,
	input  logic                          exit_enabled,
	input  logic [tehf_pkg::RUN_W-1:0]    probe_threshold,
	output tehf_pkg::health_state_t       nxt,
	output logic                          routes_public
);
	import tehf_pkg::*;

	logic [RUN_W-1:0] lim;

	// zero threshold behaves as one
	assign lim = (probe_threshold == '0) ? RUN_W'(1) : probe_threshold;

	always_comb begin
		nxt = cur;
		case (mode)
			MODE_RESTART: begin
				nxt.armed       = exit_enabled;
				nxt.policy      = exit_enabled ? ST_PENDING : ST_DISABLED;
				nxt.success_run = '0;
				nxt.failure_run = '0;
				nxt.link_up     = 1'b0;
			end
			MODE_TUNNEL: begin
				if (cur.armed) begin
					if (cur.link_up != event_flag) begin
						nxt.link_up     = event_flag;
						nxt.success_run = '0;
						nxt.failure_run = '0;
						if (event_flag && cur.policy == ST_FALLBACK)
							nxt.policy = ST_PENDING;
					end
					// any down report forces fallback, changed or not
					if (!event_flag)
						nxt.policy = ST_FALLBACK;
				end
			end
			MODE_PROBE: begin
				if (cur.armed && cur.link_up) begin
					if (event_flag) begin
						nxt.failure_run = '0;
						if (cur.success_run < lim)
							nxt.success_run = cur.success_run + RUN_W'(1);
						if (nxt.success_run >= lim)
							nxt.policy = ST_ACTIVE;
					end else begin
						nxt.success_run = '0;
						if (cur.failure_run < lim)
							nxt.failure_run = cur.failure_run + RUN_W'(1);
						if (cur.policy == ST_ACTIVE && nxt.failure_run >= lim)
							nxt.policy = ST_FALLBACK;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		routes_public = (nxt.policy == ST_ACTIVE);
	end

endmodule
